// ===== design/mclb_pkg.sv =====
// shared types and constants of the multi-channel led blinker
package mclb_pkg;

    localparam int NUM_LEDS_DEF    = 8;
    localparam int PERIOD_BITS_DEF = 16;
    localparam int IDX_W           = 3;
    localparam int HP_W            = 16;
    localparam int TIME_W          = 32;
    localparam int OUT_W           = 8;

    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_BLINK = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    // one transaction as it travels down the chain of cells
    typedef struct packed {
        cmd_t              cmd;
        logic [IDX_W-1:0]  led_index;
        logic              level;
        logic [HP_W-1:0]   half_period_ms;
        logic [TIME_W-1:0] now_ms;
        logic [OUT_W-1:0]  led_levels;
        logic [OUT_W-1:0]  toggled_mask;
    } item_t;

endpackage

// ===== design/mclb_cell.sv =====
// one led cell: holds the state of a single led and passes the transaction on
module mclb_cell #(
    parameter int CELL_IDX    = 0,
    parameter int PERIOD_BITS = mclb_pkg::PERIOD_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  mclb_pkg::item_t in_item,
    output logic            out_valid,
    output mclb_pkg::item_t out_item
);

    localparam logic [mclb_pkg::OUT_W-1:0] BIT_MASK =
        (CELL_IDX < mclb_pkg::OUT_W) ? mclb_pkg::OUT_W'(1 << CELL_IDX) : '0;

    logic [mclb_pkg::TIME_W-1:0] last_toggle_reg, last_toggle_next;
    logic [PERIOD_BITS-1:0]      half_period_reg, half_period_next;
    logic                        blink_en_reg, blink_en_next;
    logic                        level_reg, level_next;
    logic                        valid_reg;
    mclb_pkg::item_t             item_reg, item_next;

    logic [mclb_pkg::TIME_W-1:0] elapsed;
    logic                        hit;
    logic                        flip;

    assign elapsed = in_item.now_ms - last_toggle_reg;
    assign hit     = (32'(in_item.led_index) == CELL_IDX);

    always_comb
    begin
        last_toggle_next = last_toggle_reg;
        half_period_next = half_period_reg;
        blink_en_next    = blink_en_reg;
        level_next       = level_reg;
        flip             = 1'b0;
        if (in_valid)
        begin
            unique case (in_item.cmd)
                mclb_pkg::CMD_TICK:
                begin
                    if (blink_en_reg &&
                        elapsed >= mclb_pkg::TIME_W'(half_period_reg))
                    begin
                        flip             = 1'b1;
                        last_toggle_next = in_item.now_ms;
                        level_next       = ~level_reg;
                    end
                end
                mclb_pkg::CMD_SET:
                begin
                    if (hit)
                    begin
                        blink_en_next = 1'b0;
                        level_next    = in_item.level;
                    end
                end
                mclb_pkg::CMD_BLINK:
                begin
                    if (hit)
                    begin
                        blink_en_next    = 1'b1;
                        half_period_next = PERIOD_BITS'(in_item.half_period_ms);
                    end
                end
                mclb_pkg::CMD_STOP:
                begin
                    if (hit)
                    begin
                        blink_en_next = 1'b0;
                        level_next    = 1'b0;
                    end
                end
                default:
                begin
                    flip = 1'b0;
                end
            endcase
        end

        // merge this led's view into the travelling result
        item_next            = in_item;
        item_next.led_levels = (in_item.led_levels & ~BIT_MASK) |
                               (level_next ? BIT_MASK : '0);
        item_next.toggled_mask = in_item.toggled_mask | (flip ? BIT_MASK : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_toggle_reg <= '0;
            half_period_reg <= '0;
            blink_en_reg    <= 1'b0;
            level_reg       <= 1'b0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            last_toggle_reg <= last_toggle_next;
            half_period_reg <= half_period_next;
            blink_en_reg    <= blink_en_next;
            level_reg       <= level_next;
            valid_reg       <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // a reported flip has recorded the tick time
    a_flip_records_time: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (item_reg.toggled_mask & BIT_MASK) != '0)
            |-> last_toggle_reg == item_reg.now_ms)
        else $error("flipped led did not record tick time");

    // a flip only happens while blinking
    a_flip_needs_blink: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && flip) |-> blink_en_reg)
        else $error("led flipped without blinking enabled");

    // the reported level matches the level held by the cell
    a_level_reported: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && BIT_MASK != '0)
            |-> ((item_reg.led_levels & BIT_MASK) != '0) == level_reg)
        else $error("reported level differs from cell level");

endmodule

// ===== design/multi_channel_led_blinker.sv =====
// top level of the multi-channel led blinker: tick counter and chain of led cells
//
// Every cycle one transaction (set, blink, stop or tick) may be issued with start; busy
// stays low, so a new transaction is taken on every clock edge. Each transaction walks
// down a chain of NUM_LEDS cells, one cell per cycle, and each cell updates the led
// it owns as the transaction passes. The result appears on led_levels and
// toggled_mask with done high for exactly one cycle, once the transaction has left
// the last cell of the chain. Results come out in issue order, one per transaction,
// and the receiver must take them in the cycle they are shown. led_levels shows
// leds 0 to 7 only; toggled_mask is zero for anything but a tick.
module multi_channel_led_blinker #(
    parameter int NUM_LEDS    = mclb_pkg::NUM_LEDS_DEF,
    parameter int PERIOD_BITS = mclb_pkg::PERIOD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   cmd,
    input  logic [mclb_pkg::IDX_W-1:0]   led_index,
    input  logic                         level,
    input  logic [mclb_pkg::HP_W-1:0]    half_period_ms,
    output logic                         done,
    output logic [mclb_pkg::OUT_W-1:0]   led_levels,
    output logic [mclb_pkg::OUT_W-1:0]   toggled_mask
);

    // millisecond counter, advanced by each accepted tick
    logic [mclb_pkg::TIME_W-1:0] now_reg, now_next;
    logic                        accept;
    logic                        is_tick;

    // chain links: link 0 is the input, link i+1 leaves cell i
    logic                        link_valid [NUM_LEDS+1];
    mclb_pkg::item_t             link_item  [NUM_LEDS+1];

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign is_tick = (mclb_pkg::cmd_t'(cmd) == mclb_pkg::CMD_TICK);

    always_comb
    begin
        now_next = now_reg;
        if (accept && is_tick)
        begin
            now_next = now_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg <= '0;
        end
        else
        begin
            now_reg <= now_next;
        end
    end

    // the tick carries the already advanced time into the chain
    assign link_valid[0]               = accept;
    assign link_item[0].cmd            = mclb_pkg::cmd_t'(cmd);
    assign link_item[0].led_index      = led_index;
    assign link_item[0].level          = level;
    assign link_item[0].half_period_ms = half_period_ms;
    assign link_item[0].now_ms         = now_next;
    assign link_item[0].led_levels     = '0;
    assign link_item[0].toggled_mask   = '0;

    for (genvar g = 0; g < NUM_LEDS; g++)
    begin : g_cell
        mclb_cell #(
            .CELL_IDX    (g),
            .PERIOD_BITS (PERIOD_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[g]),
            .in_item   (link_item[g]),
            .out_valid (link_valid[g+1]),
            .out_item  (link_item[g+1])
        );
    end

    // last cell drives the result ports
    assign done         = link_valid[NUM_LEDS];
    assign led_levels   = link_item[NUM_LEDS].led_levels;
    assign toggled_mask = link_item[NUM_LEDS].toggled_mask;

    // every accepted transaction yields its result after the chain latency
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##NUM_LEDS done)
        else $error("result missing after chain latency");

    // the counter moves only on an accepted tick
    a_counter_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && is_tick) |=> $stable(now_reg))
        else $error("millisecond counter moved without a tick");

    // non-tick transactions never report a flip
    a_no_flip_on_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (done && link_item[NUM_LEDS].cmd != mclb_pkg::CMD_TICK) |-> toggled_mask == '0)
        else $error("flip reported for a non-tick transaction");

endmodule
